// ===== hdl/slrle_pkg.sv =====
// ----------------------------------------------------------------------------
// slrle_pkg
// shared types, codes and constants of the sprite line run-length encoder
// ----------------------------------------------------------------------------
`default_nettype none

package slrle_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  localparam int unsigned PIXEL_W = 16;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned OFS_W   = 12;
  localparam int unsigned REG_W   = 11;
  localparam int unsigned ADDR_W  = 2;
  localparam int unsigned NSLOT   = 6;

  localparam logic [ADDR_W-1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [ADDR_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [REG_W-1:0] RST_LINE_WIDTH   = 11'd1024;
  localparam logic [REG_W-1:0] RST_IMAGE_HEIGHT = 11'd1024;

  localparam logic [WORD_W-1:0]  MARK_ZERO   = 16'h00C0;
  localparam logic [WORD_W-1:0]  MARK_WHITE  = 16'h00C1;
  localparam logic [WORD_W-1:0]  MARK_LIT    = 16'h00C2;
  localparam logic [PIXEL_W-1:0] WHITE_PIXEL = 16'hFFFF;

  // slot positions inside one planned group of results
  localparam int unsigned SLOT_PREV_MARK = 0;
  localparam int unsigned SLOT_PREV_LEN  = 1;
  localparam int unsigned SLOT_LITERAL   = 2;
  localparam int unsigned SLOT_CUR_MARK  = 3;
  localparam int unsigned SLOT_CUR_LEN   = 4;
  localparam int unsigned SLOT_HEADER    = 5;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_ZERO  = 2'd1,
    KIND_WHITE = 2'd2,
    KIND_LIT   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [OFS_W-1:0]  offset;
    logic              line_end;
    logic              image_end;
  } slot_t;

  typedef struct packed {
    logic [NSLOT-1:0]        mask;
    slot_t [NSLOT-1:0]       slots;
  } plan_t;

  function automatic logic [WORD_W-1:0] mark_of(input kind_t k);
    logic [WORD_W-1:0] m;
    unique case (k)
      KIND_ZERO:  m = MARK_ZERO;
      KIND_WHITE: m = MARK_WHITE;
      default:    m = MARK_LIT;
    endcase
    return m;
  endfunction

  function automatic kind_t kind_of(input logic [PIXEL_W-1:0] px);
    kind_t k;
    if (px == '0) begin
      k = KIND_ZERO;
    end else if (px == WHITE_PIXEL) begin
      k = KIND_WHITE;
    end else begin
      k = KIND_LIT;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/slrle_plan.sv =====
// ----------------------------------------------------------------------------
// slrle_plan
// input register, run state and planning of the results of one pixel
// ----------------------------------------------------------------------------
`default_nettype none

module slrle_plan
  import slrle_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wen,
  input  wire logic [ADDR_W-1:0]  cfg_addr,
  input  wire logic [REG_W-1:0]   cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [PIXEL_W-1:0] in_pixel,
  input  wire logic               can_load,
  output logic                    load,
  output plan_t                   plan
);

  localparam int unsigned COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned WD_W   = ($clog2(MAX_WIDTH + 1) > REG_W) ?
                                   $clog2(MAX_WIDTH + 1) : REG_W;
  localparam int unsigned HD_W   = ($clog2(MAX_HEIGHT + 1) > REG_W) ?
                                   $clog2(MAX_HEIGHT + 1) : REG_W;
  localparam int unsigned RL_W   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RS_W   = $clog2(3 * MAX_WIDTH + 4);

  logic [REG_W-1:0]   line_width;
  logic [REG_W-1:0]   image_height;
  logic               pix_valid;
  logic [PIXEL_W-1:0] pix;
  kind_t              run_kind;
  logic [RS_W-1:0]    run_start;
  logic [RL_W-1:0]    run_length;
  logic [COL_W-1:0]   column;
  logic [ROW_W-1:0]   row;

  kind_t              run_kind_next;
  logic [RS_W-1:0]    run_start_next;
  logic [RL_W-1:0]    run_length_next;
  logic [COL_W-1:0]   column_next;
  logic [ROW_W-1:0]   row_next;

  logic [WD_W-1:0]    w_eff;
  logic [HD_W-1:0]    h_eff;
  kind_t              kind;
  logic               close_prev;
  logic [RS_W-1:0]    rs1;
  logic [RL_W-1:0]    rl2;
  logic [RL_W-1:0]    rl3;
  logic [RS_W-1:0]    rs2;
  logic               line_done;
  logic               last_line;

  assign load     = pix_valid && can_load;
  assign in_ready = !pix_valid || can_load;

  // effective dimensions: zero reads as one, saturated at the maximum
  always_comb begin
    if (line_width == '0) begin
      w_eff = WD_W'(1);
    end else if (WD_W'(line_width) > WD_W'(MAX_WIDTH)) begin
      w_eff = WD_W'(MAX_WIDTH);
    end else begin
      w_eff = WD_W'(line_width);
    end
    if (image_height == '0) begin
      h_eff = HD_W'(1);
    end else if (HD_W'(image_height) > HD_W'(MAX_HEIGHT)) begin
      h_eff = HD_W'(MAX_HEIGHT);
    end else begin
      h_eff = HD_W'(image_height);
    end
  end

  always_comb begin
    kind       = kind_of(pix);
    close_prev = (run_kind != KIND_NONE) && (run_kind != kind);
    rs1        = run_start;
    if (close_prev) begin
      rs1 = run_start + RS_W'(2) +
            ((run_kind == KIND_LIT) ? RS_W'(run_length) : RS_W'(0));
    end
    rl2 = (close_prev || run_kind == KIND_NONE) ? '0 : run_length;
    rl3 = rl2 + RL_W'(1);
    rs2 = rs1 + RS_W'(2) + ((kind == KIND_LIT) ? RS_W'(rl3) : RS_W'(0));
    line_done = (WD_W'(column) + WD_W'(1)) >= w_eff;
    last_line = (HD_W'(row) + HD_W'(1)) >= h_eff;

    plan.mask = '0;
    plan.slots = '0;

    plan.mask[SLOT_PREV_MARK]                = close_prev;
    plan.slots[SLOT_PREV_MARK].word          = mark_of(run_kind);
    plan.slots[SLOT_PREV_MARK].offset        = OFS_W'(run_start);
    plan.mask[SLOT_PREV_LEN]                 = close_prev;
    plan.slots[SLOT_PREV_LEN].word           = WORD_W'(run_length);
    plan.slots[SLOT_PREV_LEN].offset         = OFS_W'(run_start + RS_W'(1));

    plan.mask[SLOT_LITERAL]                  = (kind == KIND_LIT);
    plan.slots[SLOT_LITERAL].word            = pix;
    plan.slots[SLOT_LITERAL].offset          = OFS_W'(rs1 + RS_W'(2) + RS_W'(rl2));

    plan.mask[SLOT_CUR_MARK]                 = line_done;
    plan.slots[SLOT_CUR_MARK].word           = mark_of(kind);
    plan.slots[SLOT_CUR_MARK].offset         = OFS_W'(rs1);
    plan.mask[SLOT_CUR_LEN]                  = line_done;
    plan.slots[SLOT_CUR_LEN].word            = WORD_W'(rl3);
    plan.slots[SLOT_CUR_LEN].offset          = OFS_W'(rs1 + RS_W'(1));

    plan.mask[SLOT_HEADER]                   = line_done;
    plan.slots[SLOT_HEADER].word             = WORD_W'(rs2 - RS_W'(1));
    plan.slots[SLOT_HEADER].offset           = '0;
    plan.slots[SLOT_HEADER].line_end         = 1'b1;
    plan.slots[SLOT_HEADER].image_end        = last_line;

    if (line_done) begin
      run_kind_next   = KIND_NONE;
      run_start_next  = RS_W'(1);
      run_length_next = '0;
      column_next     = '0;
      row_next        = last_line ? '0 : row + ROW_W'(1);
    end else begin
      run_kind_next   = kind;
      run_start_next  = rs1;
      run_length_next = rl3;
      column_next     = column + COL_W'(1);
      row_next        = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= RST_LINE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      pix_valid    <= 1'b0;
      run_kind     <= KIND_NONE;
      run_start    <= RS_W'(1);
      run_length   <= '0;
      column       <= '0;
      row          <= '0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_addr)
          REG_LINE_WIDTH:   line_width   <= cfg_wdata;
          REG_IMAGE_HEIGHT: image_height <= cfg_wdata;
          default:          ;
        endcase
      end
      if (in_valid && in_ready) begin
        pix_valid <= 1'b1;
      end else if (load) begin
        pix_valid <= 1'b0;
      end
      if (load) begin
        run_kind   <= run_kind_next;
        run_start  <= run_start_next;
        run_length <= run_length_next;
        column     <= column_next;
        row        <= row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pix <= in_pixel;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/slrle_emit.sv =====
// ----------------------------------------------------------------------------
// slrle_emit
// one-pixel result buffer, output register; one result per cycle while ready
// ----------------------------------------------------------------------------
`default_nettype none

module slrle_emit
  import slrle_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  load,
  input  wire plan_t plan,
  output logic       can_load,
  output logic       out_valid,
  input  wire logic  out_ready,
  output slot_t      out_slot,
  output logic       out_last
);

  logic [NSLOT-1:0]  pend;
  slot_t [NSLOT-1:0] slots;
  logic [NSLOT-1:0]  low;
  logic [NSLOT-1:0]  rest;
  logic              move;
  slot_t             sel;

  always_comb begin
    low  = pend & (~pend + NSLOT'(1));
    rest = pend & ~low;
    move = (pend != '0) && (!out_valid || out_ready);
    sel  = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (low[i]) begin
        sel = slots[i];
      end
    end
    can_load = move ? (rest == '0) : (pend == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        pend <= plan.mask;
      end else if (move) begin
        pend <= rest;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= plan.slots;
    end
    if (move) begin
      out_slot <= sel;
      out_last <= (rest == '0);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sprite_line_run_length_encoder.sv =====
// ----------------------------------------------------------------------------
// sprite_line_run_length_encoder
// encodes 16-bit raster pixels into per-line runs with word offsets
// ----------------------------------------------------------------------------
// usage:
//   pixels enter on the s_axis channel, one pixel per request, raster order.
//   encoded words leave on the m_axis channel, one word per request, each with
//   its offset in the encoded line; tlast marks the line header word,
//   tuser[0] the header of the last image line, tuser[1] the last word that
//   a pixel causes.
//   line_width (index 0) and image_height (index 1) are to be written through
//   the cfg port while the block is idle; the block does not enforce this.
//   a pixel is registered in the input register when it is accepted, its
//   results are then planned into the result buffer and from there passed
//   one at a time to the output register.
//   throughput: while the receiver is ready the output register delivers one
//   word per cycle; a pixel causing at most one word keeps one pixel per cycle,
//   more words (at most six) hold the input until the last reaches the output.
//   reset returns both registers to 1024 and empties run and line state.
//   when the receiver stalls, the output word holds, the result buffer fills
//   and s_axis_tready drops once the registered pixel cannot be planned.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_line_run_length_encoder
  import slrle_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wen,
  input  wire logic [ADDR_W-1:0]  cfg_addr,
  input  wire logic [REG_W-1:0]   cfg_wdata,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [PIXEL_W-1:0] s_axis_tdata,   // pixel
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [31:0]             m_axis_tdata,   // word, offset, zero fill
  output logic                    m_axis_tlast,
  output logic [1:0]              m_axis_tuser    // image_end, last_of_item
);

  logic  can_load;
  logic  load;
  plan_t plan;
  slot_t out_slot;
  logic  out_last;

  slrle_plan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_plan (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_pixel  (s_axis_tdata),
    .can_load  (can_load),
    .load      (load),
    .plan      (plan)
  );

  slrle_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .plan      (plan),
    .can_load  (can_load),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_slot  (out_slot),
    .out_last  (out_last)
  );

  assign m_axis_tdata = {4'b0000, out_slot.offset, out_slot.word};
  assign m_axis_tlast = out_slot.line_end;
  assign m_axis_tuser = {out_last, out_slot.image_end};

endmodule

`default_nettype wire

// ===== test/tb_sprite_line_run_length_encoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sprite_line_run_length_encoder
// self-checking bench for the sprite line run-length encoder
// ----------------------------------------------------------------------------
// a queue of pixels feeds a clocked stream driver. The monitor keeps its own
// copy of the run and line state and predicts every encoded word. It checks
// each word and its flags in order.
// the bench starts with directed lines: every pixel kind, runs closing on
// kind changes and at line ends, widths and heights of zero and above the
// maximum, width changes in the middle of a line and writes to unused
// register indexes. Random runs follow under changing line and image sizes,
// with randomized gaps on both sides and long output stalls.
// ----------------------------------------------------------------------------

module tb_sprite_line_run_length_encoder;
  import slrle_pkg::*;

  localparam logic [ADDR_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [ADDR_W-1:0] REG_UNUSED_B = 2'd3;
  localparam int unsigned STALL_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic [OFS_W-1:0]  offset;
    logic              line_end;
    logic              image_end;
    logic              last_of_item;
  } enc_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wen = 1'b0;
  logic [ADDR_W-1:0]    cfg_addr = '0;
  logic [REG_W-1:0]     cfg_wdata = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [PIXEL_W-1:0]   s_axis_tdata = '0;   // pixel
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;        // word, offset, zero fill
  logic                 m_axis_tlast;
  logic [1:0]           m_axis_tuser;        // image_end, last_of_item

  logic [PIXEL_W-1:0] pixel_q[$];
  enc_word_t          enc_words[$];
  int                 err_count = 0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 stall_asked = 0;
  int                 stall_served = 0;
  int                 hold_cnt = 0;
  int                 quiet_cycles = 0;

  // predicted encoder state
  logic [REG_W-1:0] width_reg;
  logic [REG_W-1:0] height_reg;
  kind_t            run_kind;
  logic [OFS_W-1:0] run_base;
  logic [10:0]      run_len;
  logic [9:0]       col;
  logic [9:0]       line_no;

  sprite_line_run_length_encoder DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned clamp_size(input logic [REG_W-1:0] v, input int unsigned maxv);
    int unsigned r;
    r = 32'(v);
    if (r == 0) r = 1;
    if (r > maxv) r = maxv;
    return r;
  endfunction

  task automatic push_word(input logic [WORD_W-1:0] w, input int unsigned ofs,
                           input logic le, input logic ie);
    enc_word_t e;
    e.word = w;
    e.offset = ofs[OFS_W-1:0];
    e.line_end = le;
    e.image_end = ie;
    e.last_of_item = 1'b0;
    enc_words.push_back(e);
  endtask

  task automatic close_run();
    logic [WORD_W-1:0] mark;
    if (run_kind == KIND_NONE) return;
    case (run_kind)
      KIND_ZERO:  mark = MARK_ZERO;
      KIND_WHITE: mark = MARK_WHITE;
      default:    mark = MARK_LIT;
    endcase
    push_word(mark, 32'(run_base), 1'b0, 1'b0);
    push_word(WORD_W'(run_len), 32'(run_base) + 1, 1'b0, 1'b0);
    run_base = OFS_W'(32'(run_base) + 2 + ((run_kind == KIND_LIT) ? 32'(run_len) : 0));
    run_kind = KIND_NONE;
    run_len = '0;
  endtask

  task automatic encode_pixel(input logic [PIXEL_W-1:0] px);
    kind_t       k;
    int unsigned w_eff;
    int unsigned h_eff;
    int          first;
    logic        last_line;
    k = (px == '0) ? KIND_ZERO : (px == WHITE_PIXEL) ? KIND_WHITE : KIND_LIT;
    w_eff = clamp_size(width_reg, DEF_MAX_WIDTH);
    h_eff = clamp_size(height_reg, DEF_MAX_HEIGHT);
    first = enc_words.size();
    if (run_kind != KIND_NONE && run_kind != k) close_run();
    if (run_kind == KIND_NONE) begin
      run_kind = k;
      run_len = '0;
    end
    if (k == KIND_LIT) push_word(px, 32'(run_base) + 2 + 32'(run_len), 1'b0, 1'b0);
    run_len = run_len + 1'b1;
    if (32'(col) + 1 >= w_eff) begin
      last_line = (32'(line_no) + 1 >= h_eff);
      close_run();
      push_word(WORD_W'(32'(run_base) - 1), 0, 1'b1, last_line);
      run_base = OFS_W'(1);
      col = '0;
      line_no = last_line ? '0 : line_no + 1'b1;
    end else begin
      col = col + 1'b1;
    end
    if (enc_words.size() > first) enc_words[enc_words.size() - 1].last_of_item = 1'b1;
  endtask

  // stream driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pixel_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver with random stalls and long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (stall_asked != stall_served) begin
        stall_served = stall_asked;
        hold_cnt = STALL_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt = hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // monitor: tracks register writes and requests, checks encoded words
  always @(posedge clk) begin
    enc_word_t e;
    if (rst) begin
      width_reg = RST_LINE_WIDTH;
      height_reg = RST_IMAGE_HEIGHT;
      run_kind = KIND_NONE;
      run_base = OFS_W'(1);
      run_len = '0;
      col = '0;
      line_no = '0;
    end else begin
      if (cfg_wen) begin
        if (cfg_addr == REG_LINE_WIDTH) width_reg = cfg_wdata;
        else if (cfg_addr == REG_IMAGE_HEIGHT) height_reg = cfg_wdata;
      end
      if (s_axis_tvalid && s_axis_tready) encode_pixel(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (enc_words.size() == 0) begin
          $error("unexpected word %h offset %0d", m_axis_tdata[15:0], m_axis_tdata[27:16]);
          err_count++;
        end else begin
          e = enc_words.pop_front();
          if (m_axis_tdata[15:0] !== e.word) begin
            $error("word: expected %h, got %h", e.word, m_axis_tdata[15:0]);
            err_count++;
          end
          if (m_axis_tdata[27:16] !== e.offset) begin
            $error("offset: expected %0d, got %0d", e.offset, m_axis_tdata[27:16]);
            err_count++;
          end
          if (m_axis_tlast !== e.line_end) begin
            $error("line_end: expected %b, got %b", e.line_end, m_axis_tlast);
            err_count++;
          end
          if (m_axis_tuser[0] !== e.image_end) begin
            $error("image_end: expected %b, got %b", e.image_end, m_axis_tuser[0]);
            err_count++;
          end
          if (m_axis_tuser[1] !== e.last_of_item) begin
            $error("last_of_item: expected %b, got %b", e.last_of_item, m_axis_tuser[1]);
            err_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [ADDR_W-1:0] a, input logic [REG_W-1:0] d);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pixel_q.size() > 0 || s_axis_tvalid || enc_words.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // runs of one kind with random content, plus some noise pixels
  task automatic queue_runs(input int n);
    int               cnt;
    int               len;
    int               sel;
    logic [PIXEL_W-1:0] px;
    cnt = 0;
    while (cnt < n) begin
      sel = $urandom_range(9);
      len = $urandom_range(1, 5);
      for (int i = 0; i < len && cnt < n; i++) begin
        if ($urandom_range(9) == 0) px = PIXEL_W'($urandom());
        else if (sel < 3) px = '0;
        else if (sel < 5) px = WHITE_PIXEL;
        else px = PIXEL_W'($urandom_range(1, 16'hFFFE));
        pixel_q.push_back(px);
        cnt++;
      end
    end
  endtask

  initial begin
    int unsigned ph_width[9];
    int unsigned ph_height[9];
    ph_width = '{4, 1, 9, 2, 16, 3, 6, 0, 12};
    ph_height = '{3, 2, 4, 1, 2, 5, 1, 2, 3};
    send_idle_pct = 24;
    recv_idle_pct = 66;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default size, every pixel kind and both edges of the literal range
    pixel_q = '{16'h0000, 16'h0000, 16'hFFFF, 16'h1234, 16'hFFFE, 16'h0001};
    wait_idle();
    write_reg(REG_UNUSED_A, 11'h7FF);
    write_reg(REG_UNUSED_B, 11'h000);
    // width shrunk in mid line: the next pixel closes the line
    write_reg(REG_LINE_WIDTH, 11'd1);
    @(negedge clk);
    pixel_q.push_back(16'h8000);
    wait_idle();
    // zero sizes act as one
    write_reg(REG_LINE_WIDTH, 11'd0);
    write_reg(REG_IMAGE_HEIGHT, 11'd0);
    @(negedge clk);
    pixel_q = '{16'h0000, 16'hFFFF, 16'h7FFF};
    wait_idle();
    // two-pixel lines: kind change plus literal at line end gives six words
    write_reg(REG_LINE_WIDTH, 11'd2);
    write_reg(REG_IMAGE_HEIGHT, 11'd3);
    @(negedge clk);
    pixel_q = '{16'h0000, 16'hABCD, 16'hFFFF, 16'hFFFF, 16'h5555, 16'h0000,
                16'h0000, 16'hAAAA};
    wait_idle();
    // oversize registers saturate, then width drops below the current column
    write_reg(REG_LINE_WIDTH, 11'h7FF);
    write_reg(REG_IMAGE_HEIGHT, 11'h7FF);
    @(negedge clk);
    pixel_q = '{16'hFFFF, 16'h00FF, 16'h0000};
    wait_idle();
    write_reg(REG_LINE_WIDTH, 11'd3);
    @(negedge clk);
    pixel_q.push_back(16'hFF00);
    wait_idle();

    for (int p = 0; p < 9; p++) begin
      if (p == 3) begin
        send_idle_pct = 66;
        recv_idle_pct = 24;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(REG_LINE_WIDTH, REG_W'(ph_width[p]));
      write_reg(REG_IMAGE_HEIGHT, REG_W'(ph_height[p]));
      @(negedge clk);
      if (p == 1 || p == 7) stall_asked++;
      queue_runs(21);
      wait_idle();
    end

    repeat (20) @(negedge clk);

    if (err_count == 0 && enc_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
